>>> rtl/core/sqlm_pkg.sv
// sqlm_pkg: shared types, constants and case folding for the sql pattern matcher
// no dependencies
`default_nettype none
package sqlm_pkg;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned OUT_DEPTH   = 2;

	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_ONE   = 8'h31;

	typedef struct packed {
		logic [7:0] ch;
		logic       sp;
		logic       dot;
		logic       word;
		logic       last;
	} cls_t;

	function automatic logic [7:0] fold(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= 8'h41 && b <= 8'h5a) r = b + 8'd32;
		return r;
	endfunction
endpackage
`default_nettype wire

>>> rtl/core/sql_injection_pattern_matcher_core.sv
// top level of the sql injection pattern matcher
// depends on sqlm_pkg, sqlm_front, sqlm_back
//
// channel  | handshake      | fields
// input    | push / full    | text_byte, last_byte
// result   | pop / empty    | injection_found (one per string, on its last byte)
//
// one byte per cycle sustained while the result queue has room; a byte steps the
// automaton the cycle after it is pushed, and a result can be popped from the
// following cycle. reset clears the automaton and both queues. a stalled result
// queue holds the automaton, and bytes keep entering until the input queue is full.
`default_nettype none
module sql_injection_pattern_matcher_core import sqlm_pkg::*; #(
	parameter int unsigned IN_DEPTH  = QUEUE_DEPTH,
	parameter int unsigned RES_DEPTH = OUT_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] text_byte,
	input  wire logic       last_byte,
	input  wire logic       push,
	output logic            full,
	output logic            empty,
	input  wire logic       pop,
	output logic            injection_found
);
	logic q_valid, q_take;
	cls_t q_item;

	sqlm_front #(.DEPTH(IN_DEPTH)) u_front (
		.clk, .arst_n, .text_byte, .last_byte, .push, .full,
		.q_valid, .q_item, .q_take
	);

	sqlm_back #(.DEPTH(RES_DEPTH)) u_back (
		.clk, .arst_n, .q_valid, .q_item, .q_take, .empty, .pop, .injection_found
	);
endmodule
`default_nettype wire

>>> rtl/core/sqlm_front.sv
// sqlm_front: accepts bytes, folds case and classifies them into a short queue
// depends on sqlm_pkg
`default_nettype none
module sqlm_front import sqlm_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] text_byte,
	input  wire logic       last_byte,
	input  wire logic       push,
	output logic            full,
	output logic            q_valid,
	output cls_t            q_item,
	input  wire logic       q_take
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	cls_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	cls_t c;
	logic wr, rd;

	always_comb begin
		c.ch   = fold(text_byte);
		c.sp   = (c.ch == 8'd32) || (c.ch >= 8'd9 && c.ch <= 8'd13);
		c.dot  = (c.ch != 8'd10) && (c.ch != 8'd13);
		c.word = (c.ch >= 8'h61 && c.ch <= 8'h7a) || (c.ch >= 8'h30 && c.ch <= 8'h39)
			|| (c.ch == 8'h5f);
		c.last = last_byte;
	end

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_item  = mem_q[rp_q];
	assign wr      = push && !full;
	assign rd      = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/sqlm_back.sv
// sqlm_back: bit-parallel position automaton for the eight patterns and result queue
// depends on sqlm_pkg
`default_nettype none
module sqlm_back import sqlm_pkg::*; #(
	parameter int unsigned DEPTH = OUT_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	input  wire cls_t q_item,
	output logic      q_take,
	output logic      empty,
	input  wire logic pop,
	output logic      injection_found
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	logic [12:0] o1_q, n1;
	logic [15:0] o2_q, n2;
	logic [9:0]  o3_q, n3;
	logic [24:0] o4_q, n4;
	logic [5:0]  o5_q, n5;
	logic [39:0] o6_q, n6;
	logic [4:0]  o7_q, n7;
	logic [11:0] o8_q, n8;
	logic pw_q, seen_q;
	logic res_mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic [7:0] c;
	logic s, dt, w, e, k, hit, step, ofull;

	function automatic logic is_c(input logic [7:0] a, input logic [7:0] b);
		return a == b;
	endfunction

	assign ofull  = (cnt_q == (AW+1)'(DEPTH));
	assign q_take = q_valid && !ofull;
	assign step   = q_take;
	assign c  = q_item.ch;
	assign s  = q_item.sp;
	assign dt = q_item.dot;
	assign w  = q_item.word;

	always_comb begin
		n1 = '0; n2 = '0; n3 = '0; n4 = '0; n5 = '0; n6 = '0; n7 = '0; n8 = '0;
		// quote or/and ... = ... --
		e = o1_q[0] | o1_q[1];
		n1[0] = is_c(c, CH_QUOTE);
		n1[1] = s && e;
		n1[2] = e && is_c(c, "o");
		n1[3] = o1_q[2] && is_c(c, "r");
		n1[4] = e && is_c(c, "a");
		n1[5] = o1_q[4] && is_c(c, "n");
		n1[6] = o1_q[5] && is_c(c, "d");
		n1[7] = s && (o1_q[3] | o1_q[6] | o1_q[7]);
		e = o1_q[7] | o1_q[8];
		n1[8] = dt && e;
		n1[9] = is_c(c, CH_EQ) && e;
		e = o1_q[9] | o1_q[10];
		n1[10] = dt && e;
		n1[11] = is_c(c, CH_DASH) && e;
		n1[12] = is_c(c, CH_DASH) && o1_q[11];
		// union select, optionally union all select
		n2[0] = is_c(c, "u");
		n2[1] = o2_q[0] && is_c(c, "n");
		n2[2] = o2_q[1] && is_c(c, "i");
		n2[3] = o2_q[2] && is_c(c, "o");
		n2[4] = o2_q[3] && is_c(c, "n");
		n2[5] = s && (o2_q[4] | o2_q[5]);
		n2[6] = o2_q[5] && is_c(c, "a");
		n2[7] = o2_q[6] && is_c(c, "l");
		n2[8] = o2_q[7] && is_c(c, "l");
		n2[9] = s && (o2_q[8] | o2_q[9]);
		e = o2_q[5] | o2_q[9];
		n2[10] = e && is_c(c, "s");
		n2[11] = o2_q[10] && is_c(c, "e");
		n2[12] = o2_q[11] && is_c(c, "l");
		n2[13] = o2_q[12] && is_c(c, "e");
		n2[14] = o2_q[13] && is_c(c, "c");
		n2[15] = o2_q[14] && is_c(c, "t");
		// drop table
		n3[0] = is_c(c, "d");
		n3[1] = o3_q[0] && is_c(c, "r");
		n3[2] = o3_q[1] && is_c(c, "o");
		n3[3] = o3_q[2] && is_c(c, "p");
		n3[4] = s && (o3_q[3] | o3_q[4]);
		n3[5] = o3_q[4] && is_c(c, "t");
		n3[6] = o3_q[5] && is_c(c, "a");
		n3[7] = o3_q[6] && is_c(c, "b");
		n3[8] = o3_q[7] && is_c(c, "l");
		n3[9] = o3_q[8] && is_c(c, "e");
		// semicolon keyword
		e = o4_q[0] | o4_q[1];
		n4[0] = is_c(c, CH_SEMI);
		n4[1] = s && e;
		n4[2] = e && is_c(c, "d");
		n4[3] = o4_q[2] && is_c(c, "e");
		n4[4] = o4_q[3] && is_c(c, "l");
		n4[5] = o4_q[4] && is_c(c, "e");
		n4[6] = o4_q[5] && is_c(c, "t");
		n4[7] = o4_q[6] && is_c(c, "e");
		n4[8] = e && is_c(c, "d");
		n4[9] = o4_q[8] && is_c(c, "r");
		n4[10] = o4_q[9] && is_c(c, "o");
		n4[11] = o4_q[10] && is_c(c, "p");
		n4[12] = e && is_c(c, "i");
		n4[13] = o4_q[12] && is_c(c, "n");
		n4[14] = o4_q[13] && is_c(c, "s");
		n4[15] = o4_q[14] && is_c(c, "e");
		n4[16] = o4_q[15] && is_c(c, "r");
		n4[17] = o4_q[16] && is_c(c, "t");
		n4[18] = e && is_c(c, "u");
		n4[19] = o4_q[18] && is_c(c, "p");
		n4[20] = o4_q[19] && is_c(c, "d");
		n4[21] = o4_q[20] && is_c(c, "a");
		n4[22] = o4_q[21] && is_c(c, "t");
		n4[23] = o4_q[22] && is_c(c, "e");
		n4[24] = s && (o4_q[7] | o4_q[11] | o4_q[17] | o4_q[23]);
		// quote ; --
		e = o5_q[0] | o5_q[1];
		n5[0] = is_c(c, CH_QUOTE);
		n5[1] = s && e;
		n5[2] = is_c(c, CH_SEMI) && e;
		e = o5_q[2] | o5_q[3];
		n5[3] = s && e;
		n5[4] = is_c(c, CH_DASH) && e;
		n5[5] = is_c(c, CH_DASH) && o5_q[4];
		// keyword ... from/into/set
		n6[0] = !pw_q && is_c(c, "s");
		n6[1] = o6_q[0] && is_c(c, "e");
		n6[2] = o6_q[1] && is_c(c, "l");
		n6[3] = o6_q[2] && is_c(c, "e");
		n6[4] = o6_q[3] && is_c(c, "c");
		n6[5] = o6_q[4] && is_c(c, "t");
		n6[6] = !pw_q && is_c(c, "i");
		n6[7] = o6_q[6] && is_c(c, "n");
		n6[8] = o6_q[7] && is_c(c, "s");
		n6[9] = o6_q[8] && is_c(c, "e");
		n6[10] = o6_q[9] && is_c(c, "r");
		n6[11] = o6_q[10] && is_c(c, "t");
		n6[12] = !pw_q && is_c(c, "u");
		n6[13] = o6_q[12] && is_c(c, "p");
		n6[14] = o6_q[13] && is_c(c, "d");
		n6[15] = o6_q[14] && is_c(c, "a");
		n6[16] = o6_q[15] && is_c(c, "t");
		n6[17] = o6_q[16] && is_c(c, "e");
		n6[18] = !pw_q && is_c(c, "d");
		n6[19] = o6_q[18] && is_c(c, "e");
		n6[20] = o6_q[19] && is_c(c, "l");
		n6[21] = o6_q[20] && is_c(c, "e");
		n6[22] = o6_q[21] && is_c(c, "t");
		n6[23] = o6_q[22] && is_c(c, "e");
		k = o6_q[5] | o6_q[11] | o6_q[17] | o6_q[23];
		n6[24] = dt && ((k && !w) || o6_q[24]);
		n6[25] = (is_c(c, CH_QUOTE) || is_c(c, CH_SEMI)) && (k || o6_q[24]);
		n6[26] = is_c(c, CH_DASH);
		n6[27] = is_c(c, CH_DASH) && o6_q[26];
		e = o6_q[25] | o6_q[27] | o6_q[28];
		n6[28] = dt && e;
		e = e && !pw_q;
		n6[29] = e && is_c(c, "f");
		n6[30] = o6_q[29] && is_c(c, "r");
		n6[31] = o6_q[30] && is_c(c, "o");
		n6[32] = o6_q[31] && is_c(c, "m");
		n6[33] = e && is_c(c, "i");
		n6[34] = o6_q[33] && is_c(c, "n");
		n6[35] = o6_q[34] && is_c(c, "t");
		n6[36] = o6_q[35] && is_c(c, "o");
		n6[37] = e && is_c(c, "s");
		n6[38] = o6_q[37] && is_c(c, "e");
		n6[39] = o6_q[38] && is_c(c, "t");
		// 1 = 1
		e = o7_q[0] | o7_q[1];
		n7[0] = is_c(c, CH_ONE);
		n7[1] = s && e;
		n7[2] = is_c(c, CH_EQ) && e;
		e = o7_q[2] | o7_q[3];
		n7[3] = s && e;
		n7[4] = is_c(c, CH_ONE) && e;
		// quote or quote = quote
		e = o8_q[0] | o8_q[1];
		n8[0] = is_c(c, CH_QUOTE);
		n8[1] = s && e;
		n8[2] = e && is_c(c, "o");
		n8[3] = o8_q[2] && is_c(c, "r");
		n8[4] = s && (o8_q[3] | o8_q[4]);
		n8[5] = is_c(c, CH_QUOTE) && o8_q[4];
		e = o8_q[5] | o8_q[6];
		n8[6] = dt && e;
		n8[7] = is_c(c, CH_QUOTE) && e;
		e = o8_q[7] | o8_q[8];
		n8[8] = s && e;
		n8[9] = is_c(c, CH_EQ) && e;
		e = o8_q[9] | o8_q[10];
		n8[10] = s && e;
		n8[11] = is_c(c, CH_QUOTE) && e;

		hit = n1[12] | n2[15] | n3[9] | n4[24] | n5[5] | n7[4] | n8[11]
			| (!w && (o6_q[32] | o6_q[36] | o6_q[39]))
			| (q_item.last && (n6[32] | n6[36] | n6[39]));
	end

	assign empty = (cnt_q == '0);
	assign injection_found = res_mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (step && q_item.last) res_mem_q[wp_q] <= seen_q | hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o1_q <= '0; o2_q <= '0; o3_q <= '0; o4_q <= '0;
			o5_q <= '0; o6_q <= '0; o7_q <= '0; o8_q <= '0;
			pw_q <= 1'b0; seen_q <= 1'b0;
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (step) begin
				if (q_item.last) begin
					o1_q <= '0; o2_q <= '0; o3_q <= '0; o4_q <= '0;
					o5_q <= '0; o6_q <= '0; o7_q <= '0; o8_q <= '0;
					pw_q <= 1'b0; seen_q <= 1'b0;
					wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
				end else begin
					o1_q <= n1; o2_q <= n2; o3_q <= n3; o4_q <= n4;
					o5_q <= n5; o6_q <= n6; o7_q <= n7; o8_q <= n8;
					pw_q <= w; seen_q <= seen_q | hit;
				end
			end
			if (pop && !empty) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(step && q_item.last) - (AW+1)'(pop && !empty);
		end
	end
endmodule
`default_nettype wire

>>> dv/testbench.sv
// self-checking testbench for sql_injection_pattern_matcher_core: random and directed strings,
// a bit-parallel automaton predictor per byte, results compared in order at the pop side
// depends on sqlm_pkg and the matcher rtl
`default_nettype none
module testbench;
	import sqlm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] ch;
		logic       fin;
	} byte_item_t;

	logic       clk;
	logic       arst_n;
	logic [7:0] text_byte;
	logic       last_byte;
	logic       push;
	logic       full;
	logic       empty;
	logic       pop;
	logic       injection_found;

	sql_injection_pattern_matcher_core dut (
		.clk(clk), .arst_n(arst_n), .text_byte(text_byte), .last_byte(last_byte),
		.push(push), .full(full), .empty(empty), .pop(pop),
		.injection_found(injection_found)
	);

	byte_item_t pending_bytes[$];
	logic       verdicts_due[$];
	logic [63:0] act_lo, act_hi;
	logic        prev_word, seen_match;
	int  mismatches = 0;
	int  idle_cycles = 0;
	int  hold_off = 0;
	bit  stall_go = 0;
	bit  stall_done = 0;
	bit  timed_out = 0;

	initial clk = 0;
	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	function automatic logic [63:0] word_chain(logic [63:0] old, int at, string w, bit enter,
			logic [7:0] c);
		logic [63:0] r;
		bit go;
		r = '0;
		go = enter;
		for (int k = 0; k < w.len(); k++) begin
			if (w[k] == c && go) r[at + k] = 1'b1;
			go = old[at + k];
		end
		return r;
	endfunction

	// advances the predicted automaton by one byte; returns 1 when a verdict is due
	function automatic bit scan_byte(logic [7:0] raw, logic fin, output logic verdict);
		logic [7:0] c;
		bit s, dt, w, pw, hit, e, k;
		logic [63:0] o1, o2, o3, o4, o5, o6, o7, o8;
		logic [63:0] n1, n2, n3, n4, n5, n6, n7, n8;
		c = (raw >= "A" && raw <= "Z") ? raw + 8'd32 : raw;
		s = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
		dt = (c != 8'd10) && (c != 8'd13);
		w = (c >= "a" && c <= "z") || (c >= "0" && c <= "9") || c == "_";
		pw = prev_word;
		o1 = (act_lo >> 0) & ((64'd1 << 13) - 1);
		o2 = (act_lo >> 13) & ((64'd1 << 16) - 1);
		o3 = (act_lo >> 29) & ((64'd1 << 10) - 1);
		o4 = (act_lo >> 39) & ((64'd1 << 25) - 1);
		o5 = (act_hi >> 0) & ((64'd1 << 6) - 1);
		o6 = (act_hi >> 6) & ((64'd1 << 40) - 1);
		o7 = (act_hi >> 46) & ((64'd1 << 5) - 1);
		o8 = (act_hi >> 51) & ((64'd1 << 12) - 1);
		n1 = '0; n2 = '0; n3 = '0; n4 = '0; n5 = '0; n6 = '0; n7 = '0; n8 = '0;

		e = o1[0] || o1[1];
		n1[0] = c == CH_QUOTE; n1[1] = s && e;
		n1 |= word_chain(o1, 2, "or", e, c) | word_chain(o1, 4, "and", e, c);
		n1[7] = s && (o1[3] || o1[6] || o1[7]);
		e = o1[7] || o1[8];
		n1[8] = dt && e; n1[9] = c == CH_EQ && e;
		e = o1[9] || o1[10];
		n1[10] = dt && e; n1[11] = c == CH_DASH && e;
		n1[12] = c == CH_DASH && o1[11];

		n2 = word_chain(o2, 0, "union", 1, c);
		n2[5] = s && (o2[4] || o2[5]);
		n2 |= word_chain(o2, 6, "all", o2[5], c);
		n2[9] = s && (o2[8] || o2[9]);
		n2 |= word_chain(o2, 10, "select", o2[5] || o2[9], c);

		n3 = word_chain(o3, 0, "drop", 1, c);
		n3[4] = s && (o3[3] || o3[4]);
		n3 |= word_chain(o3, 5, "table", o3[4], c);

		e = o4[0] || o4[1];
		n4[0] = c == CH_SEMI; n4[1] = s && e;
		n4 |= word_chain(o4, 2, "delete", e, c) | word_chain(o4, 8, "drop", e, c);
		n4 |= word_chain(o4, 12, "insert", e, c) | word_chain(o4, 18, "update", e, c);
		n4[24] = s && (o4[7] || o4[11] || o4[17] || o4[23]);

		e = o5[0] || o5[1];
		n5[0] = c == CH_QUOTE; n5[1] = s && e; n5[2] = c == CH_SEMI && e;
		e = o5[2] || o5[3];
		n5[3] = s && e; n5[4] = c == CH_DASH && e;
		n5[5] = c == CH_DASH && o5[4];

		n6 = word_chain(o6, 0, "select", !pw, c) | word_chain(o6, 6, "insert", !pw, c);
		n6 |= word_chain(o6, 12, "update", !pw, c) | word_chain(o6, 18, "delete", !pw, c);
		k = o6[5] || o6[11] || o6[17] || o6[23];
		n6[24] = dt && ((k && !w) || o6[24]);
		n6[25] = (c == CH_QUOTE || c == CH_SEMI) && (k || o6[24]);
		n6[26] = c == CH_DASH; n6[27] = c == CH_DASH && o6[26];
		e = o6[25] || o6[27] || o6[28];
		n6[28] = dt && e;
		n6 |= word_chain(o6, 29, "from", e && !pw, c) | word_chain(o6, 33, "into", e && !pw, c);
		n6 |= word_chain(o6, 37, "set", e && !pw, c);

		e = o7[0] || o7[1];
		n7[0] = c == CH_ONE; n7[1] = s && e; n7[2] = c == CH_EQ && e;
		e = o7[2] || o7[3];
		n7[3] = s && e; n7[4] = c == CH_ONE && e;

		e = o8[0] || o8[1];
		n8[0] = c == CH_QUOTE; n8[1] = s && e;
		n8 |= word_chain(o8, 2, "or", e, c);
		n8[4] = s && (o8[3] || o8[4]);
		n8[5] = c == CH_QUOTE && o8[4];
		e = o8[5] || o8[6];
		n8[6] = dt && e; n8[7] = c == CH_QUOTE && e;
		e = o8[7] || o8[8];
		n8[8] = s && e; n8[9] = c == CH_EQ && e;
		e = o8[9] || o8[10];
		n8[10] = s && e; n8[11] = c == CH_QUOTE && e;

		hit = n1[12] || n2[15] || n3[9] || n4[24] || n5[5] || n7[4] || n8[11];
		if (!w && (o6[32] || o6[36] || o6[39])) hit = 1;
		if (fin && (n6[32] || n6[36] || n6[39])) hit = 1;

		act_lo = n1 | (n2 << 13) | (n3 << 29) | (n4 << 39);
		act_hi = n5 | (n6 << 6) | (n7 << 46) | (n8 << 51);
		prev_word = w;
		if (hit) seen_match = 1;
		verdict = seen_match;
		if (fin) begin
			act_lo = '0; act_hi = '0; prev_word = 0; seen_match = 0;
		end
		return fin;
	endfunction

	task automatic add_string(string t);
		for (int i = 0; i < t.len(); i++)
			pending_bytes.insert(pending_bytes.size(), '{ch: t[i], fin: (i == t.len() - 1)});
	endtask

	function automatic string random_fragment();
		string frags[] = '{"'", " ", "\t", "\n", "\r", ";", "--", "=", "1", "or", "OR", "and",
			"union", "all", "select", "SELECT", "drop", "table", "delete", "insert",
			"update", "from", "into", "set", "x", "_", "9", ".", "\"", "\x80", "\xff",
			"\x0b", "\x0c", "Z", "@"};
		string r;
		r = frags[$urandom_range(0, frags.size() - 1)];
		if ($urandom_range(0, 9) == 0) r = string'(byte'($urandom_range(0, 255)));
		return r;
	endfunction

	// driver
	int  push_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		logic v;
		if (!arst_n) begin
			push <= 0;
			text_byte <= '0;
			last_byte <= 0;
			push_gap <= 0;
		end else begin
			if (push && !full) begin
				if (scan_byte(text_byte, last_byte, v))
					verdicts_due.insert(verdicts_due.size(), v);
				void'(pending_bytes.pop_front());
			end
			if (push && full) begin
				// keep offering the same byte
			end else if (push_gap > 0) begin
				push <= 0;
				push_gap <= push_gap - 1;
			end else if (pending_bytes.size() > 0) begin
				byte_item_t it;
				it = pending_bytes[0];
				if (!(push && !full) || $urandom_range(0, 3) != 0) begin
					push <= 1;
					text_byte <= it.ch;
					last_byte <= it.fin;
					push_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
				end else begin
					push <= 0;
					push_gap <= $urandom_range(0, 8);
				end
			end else begin
				push <= 0;
			end
		end
	end

	// monitor
	int pop_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		logic exp_v;
		if (!arst_n) begin
			pop <= 0;
			pop_gap <= 0;
			hold_off <= 0;
			stall_done <= 0;
		end else begin
			if (pop && !empty) begin
				if (verdicts_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected transfer: found=%b", injection_found);
				end else begin
					exp_v = verdicts_due.pop_front();
					if (injection_found !== exp_v) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected found=%b actual %b", exp_v,
								injection_found);
					end
				end
			end
			if (stall_go && !stall_done) begin
				// long receiver stall while bytes keep coming
				pop <= 0;
				stall_done <= 1;
				hold_off <= 200;
			end else if (hold_off > 0) begin
				pop <= 0;
				hold_off <= hold_off - 1;
			end else if (pop_gap > 0) begin
				pop <= 0;
				pop_gap <= pop_gap - 1;
			end else begin
				pop <= 1;
				pop_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 8) : 0;
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if (arst_n && !((push && !full) || (pop && !empty))) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 2000 && hold_off == 0) timed_out <= 1;
		end else begin
			idle_cycles <= 0;
		end
	end

	initial begin
		string str;
		act_lo = '0; act_hi = '0; prev_word = 0; seen_match = 0;
		arst_n = 0;
		push = 0; pop = 0; text_byte = '0; last_byte = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;

		add_string("' or 1=1 --");
		add_string("x' AND a=b--");
		add_string("UNION ALL SELECT x");
		add_string("union\tselect");
		add_string("drop  table t");
		add_string("a; DELETE x");
		add_string("';--");
		add_string("select a ; b from");
		add_string("selectx ; from");
		add_string("--x into y");
		add_string("update t; set");
		add_string("1 = 1");
		add_string("' or 'a'='");
		add_string("\xff\x80\x00\n\r");
		add_string("Z");
		add_string("_");
		add_string("--\nfrom ");
		add_string("-- sets");

		for (int n = 0; n < 120; n++) begin
			str = "";
			for (int f = $urandom_range(1, 8); f > 0; f--) str = {str, random_fragment()};
			if (n == 60) begin
				while (!timed_out && (verdicts_due.size() > 0 || pending_bytes.size() > 0))
					@(posedge clk);
				stall_go = 1;
			end
			add_string(str);
		end
		for (int i = 0; i < 200; i++)
			pending_bytes.insert(pending_bytes.size(),
				'{ch: 8'($urandom_range(0, 255)), fin: ($urandom_range(0, 15) == 0)});
		pending_bytes.insert(pending_bytes.size(), '{ch: "a", fin: 1});

		while (!timed_out && (pending_bytes.size() > 0 || verdicts_due.size() > 0 || push))
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (timed_out) begin
			$display("simulation failed");
		end else if (mismatches == 0 && verdicts_due.size() == 0 && pending_bytes.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
